// File: sv/usb_in_transfer_packetizer_core_defines.svh
// assertion macros for the usb in transfer packetizer
`ifndef USB_IN_TRANSFER_PACKETIZER_CORE_DEFINES_SVH
`define USB_IN_TRANSFER_PACKETIZER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define UITP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define UITP_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`else
`define UITP_ASSERT(label, clk, rst_n, prop)
`define UITP_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: sv/uitp_pkg.sv
// package with codes and constants of the usb in transfer packetizer
`timescale 1ns / 1ps
package uitp_pkg;
  localparam int unsigned BufDepth = 64;
  localparam int unsigned MaxPacket = 8;
  localparam logic [15:0] CrcPoly = 16'ha001;
  localparam logic [15:0] CrcInit = 16'hffff;
  localparam logic [7:0] PidData0 = 8'hc3;
  localparam logic [7:0] PidData1 = 8'h4b;

  typedef enum logic [2:0] {
    ACT_LOAD = 3'd0, ACT_START = 3'd1, ACT_SETUP = 3'd2, ACT_OUT = 3'd3,
    ACT_DATA0 = 3'd4, ACT_DATA1 = 3'd5, ACT_ACK = 3'd6, ACT_IGNORE = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    KIND_BYTE = 3'd0, KIND_NOTHING = 3'd1, KIND_BUSY = 3'd2,
    KIND_FINISHED = 3'd3, KIND_ABORTED = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    TK_NONE = 3'd0, TK_SETUP = 3'd1, TK_OUT = 3'd5
  } tkind_e;

  typedef struct packed {
    logic       init;
    logic       step;
    logic [7:0] data;
  } crc_ctl_t;
endpackage

// File: sv/uitp_crc.sv
// bit-serial crc-16/usb unit, one bit per cycle while step is set
`timescale 1ns / 1ps
module uitp_crc import uitp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  crc_ctl_t   ctl_i,
  input  logic [2:0] bit_sel_i,
  output logic [15:0] crc_o
);
  logic [15:0] crc_q, crc_d;
  logic        fb;

  always_comb begin
    fb = crc_q[0] ^ ctl_i.data[bit_sel_i];
    crc_d = crc_q;
    if (ctl_i.init) begin
      crc_d = CrcInit;
    end else if (ctl_i.step) begin
      crc_d = fb ? ((crc_q >> 1) ^ CrcPoly) : (crc_q >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;
endmodule

// File: sv/uitp_txbuf.sv
// transmit buffer memory with registered read
`timescale 1ns / 1ps
module uitp_txbuf import uitp_pkg::*; #(
  parameter int unsigned BUF_DEPTH = BufDepth
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(BUF_DEPTH)-1:0] waddr_i,
  input  logic [7:0]                   wdata_i,
  input  logic [$clog2(BUF_DEPTH)-1:0] raddr_i,
  output logic [7:0]                   rdata_o
);
  logic [7:0] mem_q [BUF_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: sv/usb_in_transfer_packetizer_core.sv
// top level of the usb in transfer packetizer
// channel | direction | handshake
// in      | input     | in_valid_i / in_stall_o
// out     | output    | out_valid_o / out_stall_i
// cfg     | input     | cfg_valid_i / cfg_ready_o
// an accepted item is decoded into the output fields; without a packet, ST_SINGLE then shows one result
// a packet shows its pid, then per data byte ST_READ reads, ST_CRC steps each bit and ST_EMIT outputs it
// the two crc bytes follow from ST_CRCLO and ST_CRCHI, or two zero bytes for a zero-length packet
// other actions hold the input through ST_SINGLE; output stalls lengthen every hold
// reset is asynchronous and clears all control state; the buffer is undefined until written
// a new transaction is taken only once the output register is empty
`timescale 1ns / 1ps
`include "usb_in_transfer_packetizer_core_defines.svh"
module usb_in_transfer_packetizer_core import uitp_pkg::*; #(
  parameter int unsigned BUF_DEPTH = BufDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic [3:0] endpoint_i,
  input  logic [6:0] transfer_length_i,
  input  logic [5:0] byte_index_i,
  input  logic [7:0] byte_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [3:0] out_endpoint_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i
);
  localparam int unsigned AW = $clog2(BUF_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PID, ST_READ, ST_CRC, ST_EMIT, ST_CRCLO, ST_CRCHI, ST_SINGLE
  } state_e;

  state_e      state_q;
  logic [6:0]  dev_addr_q;
  logic [15:0] toggle_q;
  logic [3:0]  tok_ep_q, xfer_ep_q;
  logic        active_q, pending_q;
  logic [7:0]  left_q;
  logic [6:0]  offset_q;
  tkind_e      tkind_q;
  logic [3:0]  cnt_q, n_q;
  logic [2:0]  bit_q;
  logic        zlp_q;
  logic        ov_q;
  logic [2:0]  okind_q;
  logic [7:0]  obyte_q;
  logic [3:0]  oep_q;
  logic        olast_q;
  logic [7:0]  rdata;
  logic [15:0] crc;
  crc_ctl_t    crc_ctl;
  logic        accept, out_free, is_start, is_ack;
  logic [AW-1:0] raddr;
  logic [15:0] crc_inv;
  logic [15:0] tog_next;
  logic [7:0]  pid;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || ov_q;
  assign cfg_ready_o = 1'b1;
  assign out_free = !ov_q || !out_stall_i;
  assign raddr = AW'(32'(offset_q) + 32'(cnt_q));
  assign crc_inv = ~crc;
  assign is_start = (action_i == ACT_START);
  assign is_ack = (action_i == ACT_ACK);

  always_comb begin
    tog_next = toggle_q;
    if (is_ack) begin
      tog_next = toggle_q ^ (16'd1 << tok_ep_q);
    end
  end
  assign pid = tog_next[tok_ep_q] ? PidData1 : PidData0;

  always_comb begin
    crc_ctl.init = accept;
    crc_ctl.step = (state_q == ST_CRC);
    crc_ctl.data = rdata;
  end

  uitp_txbuf #(.BUF_DEPTH(BUF_DEPTH)) u_buf (
    .clk_i   (clk_i),
    .we_i    (accept && action_i == ACT_LOAD),
    .waddr_i (AW'(byte_index_i)),
    .wdata_i (byte_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  uitp_crc u_crc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (crc_ctl),
    .bit_sel_i (bit_q),
    .crc_o     (crc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dev_addr_q <= '0;
      toggle_q <= '0;
      tok_ep_q <= '0;
      xfer_ep_q <= '0;
      active_q <= 1'b0;
      pending_q <= 1'b0;
      left_q <= '0;
      offset_q <= '0;
      tkind_q <= TK_NONE;
      cnt_q <= '0;
      n_q <= '0;
      bit_q <= '0;
      zlp_q <= 1'b0;
      ov_q <= 1'b0;
      okind_q <= KIND_NOTHING;
      obyte_q <= '0;
      oep_q <= '0;
      olast_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        dev_addr_q <= cfg_data_i;
      end
      if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            okind_q <= KIND_NOTHING;
            obyte_q <= '0;
            oep_q <= '0;
            olast_q <= 1'b1;
            state_q <= ST_SINGLE;
            case (action_i)
              ACT_START: begin
                if (active_q || pending_q || dev_addr_q == '0) begin
                  okind_q <= KIND_BUSY;
                  oep_q <= endpoint_i;
                end else begin
                  xfer_ep_q <= endpoint_i;
                  left_q <= {1'b0, transfer_length_i};
                  offset_q <= '0;
                  active_q <= 1'b1;
                  pending_q <= 1'b1;
                  if (transfer_length_i == '0 && endpoint_i != '0) begin
                    active_q <= 1'b0;
                    pending_q <= 1'b0;
                    okind_q <= KIND_FINISHED;
                    oep_q <= endpoint_i;
                  end else begin
                    zlp_q <= (transfer_length_i == '0);
                    n_q <= (transfer_length_i > 7'(MaxPacket)) ? 4'(MaxPacket)
                                                               : transfer_length_i[3:0];
                    obyte_q <= pid;
                    okind_q <= KIND_BYTE;
                    oep_q <= endpoint_i;
                    olast_q <= 1'b0;
                    state_q <= ST_PID;
                  end
                end
              end
              ACT_SETUP: begin
                tkind_q <= TK_SETUP;
                if (pending_q) begin
                  okind_q <= KIND_ABORTED;
                  oep_q <= xfer_ep_q;
                end
                active_q <= 1'b0;
                pending_q <= 1'b0;
                left_q <= '0;
                offset_q <= '0;
                tok_ep_q <= endpoint_i;
              end
              ACT_OUT: begin
                tok_ep_q <= endpoint_i;
                tkind_q <= TK_OUT;
              end
              ACT_DATA0, ACT_DATA1: begin
                if (action_i == ACT_DATA0) begin
                  toggle_q <= toggle_q | (16'd1 << tok_ep_q);
                end else begin
                  toggle_q <= toggle_q & ~(16'd1 << tok_ep_q);
                end
                if (tkind_q == TK_SETUP) begin
                  tkind_q <= TK_NONE;
                end
              end
              ACT_ACK: begin
                toggle_q <= tog_next;
                if (!active_q || left_q < 8'(MaxPacket)) begin
                  if (pending_q && active_q) begin
                    okind_q <= KIND_FINISHED;
                    oep_q <= xfer_ep_q;
                  end
                  active_q <= 1'b0;
                  pending_q <= 1'b0;
                  left_q <= '0;
                  offset_q <= '0;
                  if (tkind_q == TK_OUT) begin
                    tkind_q <= TK_NONE;
                  end
                end else if (left_q == 8'(MaxPacket) && xfer_ep_q != '0) begin
                  active_q <= 1'b0;
                  pending_q <= 1'b0;
                  left_q <= '0;
                  offset_q <= '0;
                  okind_q <= KIND_FINISHED;
                  oep_q <= xfer_ep_q;
                end else begin
                  left_q <= left_q - 8'(MaxPacket);
                  offset_q <= offset_q + 7'(MaxPacket);
                  pending_q <= 1'b1;
                  zlp_q <= (left_q == 8'(MaxPacket));
                  n_q <= (left_q - 8'(MaxPacket) > 8'(MaxPacket)) ? 4'(MaxPacket)
                         : 4'(left_q - 8'(MaxPacket));
                  obyte_q <= pid;
                  okind_q <= KIND_BYTE;
                  oep_q <= xfer_ep_q;
                  olast_q <= 1'b0;
                  state_q <= ST_PID;
                end
              end
              default: begin
              end
            endcase
            if (!is_start && !is_ack) begin
              state_q <= ST_SINGLE;
            end
          end
        end
        ST_SINGLE, ST_PID: begin
          if (out_free) begin
            ov_q <= 1'b1;
            cnt_q <= '0;
            if (state_q == ST_SINGLE) begin
              state_q <= ST_IDLE;
            end else if (zlp_q || n_q == '0) begin
              zlp_q <= 1'b1;
              state_q <= ST_CRCLO;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          bit_q <= '0;
          state_q <= ST_CRC;
        end
        ST_CRC: begin
          bit_q <= bit_q + 3'd1;
          if (bit_q == 3'd7) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            ov_q <= 1'b1;
            obyte_q <= rdata;
            cnt_q <= cnt_q + 4'd1;
            if (cnt_q + 4'd1 == n_q) begin
              state_q <= ST_CRCLO;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_CRCLO: begin
          if (out_free) begin
            ov_q <= 1'b1;
            obyte_q <= zlp_q ? 8'd0 : crc_inv[7:0];
            state_q <= ST_CRCHI;
          end
        end
        ST_CRCHI: begin
          if (out_free) begin
            ov_q <= 1'b1;
            obyte_q <= zlp_q ? 8'd0 : crc_inv[15:8];
            olast_q <= 1'b1;
            zlp_q <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign kind_o = okind_q;
  assign out_byte_o = obyte_q;
  assign out_endpoint_o = oep_q;
  assign last_o = olast_q;

  `UITP_ASSERT(a_busy_no_accept, clk_i, rst_ni, (state_q != ST_IDLE) |-> in_stall_o)
  `UITP_ASSERT_NEVER(a_packet_without_pending, clk_i, rst_ni, ov_q && okind_q == KIND_BYTE && !pending_q)
  `UITP_ASSERT(a_crc_walk, clk_i, rst_ni, (state_q == ST_READ) |=> (state_q == ST_CRC))
endmodule

// File: tb/sv/usb_in_transfer_packetizer_core_tb.sv
// testbench for the usb in transfer packetizer core
`timescale 1ns / 1ps
module usb_in_transfer_packetizer_core_tb;
  import uitp_pkg::*;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [3:0] ep;
    logic       last;
  } result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] action_i;
  logic [3:0] endpoint_i;
  logic [6:0] transfer_length_i;
  logic [5:0] byte_index_i;
  logic [7:0] byte_value_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] kind_o;
  logic [7:0] out_byte_o;
  logic [3:0] out_endpoint_o;
  logic       last_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [6:0] cfg_data_i;

  usb_in_transfer_packetizer_core dut (.*);

  // predictor state
  logic [7:0]  buf_mem [BufDepth];
  bit          buf_written [BufDepth];
  logic [15:0] toggles;
  logic [3:0]  tok_ep;
  logic [3:0]  xfer_ep;
  bit          xfer_active;
  bit          pkt_pending;
  logic [7:0]  remaining;
  int unsigned rd_offset;
  logic [2:0]  tok_kind;
  logic [6:0]  dev_addr;

  result_t     expected_q[$];
  int          mismatches;
  int unsigned cycles = 0;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    for (int i = 0; i < 8; i++) begin
      if (crc[0] ^ b[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

  function automatic void push_result(kind_e k, logic [7:0] d, logic [3:0] e);
    result_t r;
    r.kind = k;
    r.data = d;
    r.ep = e;
    r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void clear_transmit();
    xfer_active = 0;
    pkt_pending = 0;
    remaining = 0;
    rd_offset = 0;
  endfunction

  function automatic void queue_next_packet();
    logic [7:0]  pid;
    logic [15:0] crc;
    int unsigned n;
    logic [7:0]  b;
    crc = CrcInit;
    pkt_pending = 1;
    pid = toggles[tok_ep] ? PidData1 : PidData0;
    if (remaining == 0) begin
      if (xfer_ep != 0) begin
        clear_transmit();
        push_result(KIND_FINISHED, 8'h00, xfer_ep);
        return;
      end
      push_result(KIND_BYTE, pid, xfer_ep);
      push_result(KIND_BYTE, 8'h00, xfer_ep);
      push_result(KIND_BYTE, 8'h00, xfer_ep);
      return;
    end
    n = (remaining > MaxPacket) ? MaxPacket : remaining;
    push_result(KIND_BYTE, pid, xfer_ep);
    for (int i = 0; i < n; i++) begin
      b = buf_mem[(rd_offset + i) % BufDepth];
      crc = crc16_byte(crc, b);
      push_result(KIND_BYTE, b, xfer_ep);
    end
    crc = ~crc;
    push_result(KIND_BYTE, crc[7:0], xfer_ep);
    push_result(KIND_BYTE, crc[15:8], xfer_ep);
  endfunction

  function automatic void predict_transaction(action_e act, logic [3:0] ep, logic [6:0] len,
                                              logic [5:0] idx, logic [7:0] val);
    int before_n;
    result_t r;
    before_n = expected_q.size();
    case (act)
      ACT_LOAD: begin
        buf_mem[idx] = val;
        buf_written[idx] = 1;
      end
      ACT_START: begin
        if (xfer_active || pkt_pending || dev_addr == 0) begin
          push_result(KIND_BUSY, 8'h00, ep);
        end else begin
          xfer_ep = ep;
          remaining = {1'b0, len};
          rd_offset = 0;
          xfer_active = 1;
          queue_next_packet();
        end
      end
      ACT_SETUP: begin
        tok_kind = TK_SETUP;
        if (pkt_pending) push_result(KIND_ABORTED, 8'h00, xfer_ep);
        clear_transmit();
        tok_ep = ep;
      end
      ACT_OUT: begin
        tok_ep = ep;
        tok_kind = TK_OUT;
      end
      ACT_DATA0, ACT_DATA1: begin
        toggles[tok_ep] = (act == ACT_DATA0);
        if (tok_kind == TK_SETUP) tok_kind = TK_NONE;
      end
      ACT_ACK: begin
        toggles[tok_ep] = ~toggles[tok_ep];
        if (!xfer_active || remaining < MaxPacket) begin
          if (pkt_pending && xfer_active) push_result(KIND_FINISHED, 8'h00, xfer_ep);
          clear_transmit();
          if (tok_kind == TK_OUT) tok_kind = TK_NONE;
        end else begin
          remaining = remaining - MaxPacket;
          rd_offset += MaxPacket;
          pkt_pending = 0;
          queue_next_packet();
        end
      end
      default: ;
    endcase
    if (expected_q.size() == before_n) push_result(KIND_NOTHING, 8'h00, 4'h0);
    r = expected_q.pop_back();
    r.last = 1'b1;
    expected_q.push_back(r);
  endfunction

  // a start or ack may only read buffer entries that were written
  function automatic bit reads_are_safe(action_e act, logic [6:0] len);
    int unsigned n;
    int unsigned off;
    if (act == ACT_START) begin
      if (xfer_active || pkt_pending || dev_addr == 0) return 1;
      n = (len > MaxPacket) ? MaxPacket : len;
      off = 0;
    end else if (act == ACT_ACK) begin
      if (!xfer_active || remaining < MaxPacket) return 1;
      n = remaining - MaxPacket;
      if (n > MaxPacket) n = MaxPacket;
      off = rd_offset + MaxPacket;
    end else begin
      return 1;
    end
    for (int i = 0; i < n; i++) begin
      if (!buf_written[(off + i) % BufDepth]) return 0;
    end
    return 1;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    result_t got;
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {kind_o, out_byte_o, out_endpoint_o, last_o};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected kind %0d byte %h ep %0d last %0b",
                     exp_r.kind, exp_r.data, exp_r.ep, exp_r.last);
            $display("          actual   kind %0d byte %h ep %0d last %0b",
                     got.kind, got.data, got.ep, got.last);
          end
        end
      end
    end
  end

  // receiver stall
  initial begin
    int unsigned gap;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  task automatic send_transaction(action_e act, logic [3:0] ep, logic [6:0] len,
                                  logic [5:0] idx, logic [7:0] val);
    int unsigned gap;
    bit safe;
    safe = reads_are_safe(act, len);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0 || !safe) in_valid_i <= 1'b0;
    if (!safe) return;
    repeat (gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    action_i <= act;
    endpoint_i <= ep;
    transfer_length_i <= len;
    byte_index_i <= idx;
    byte_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_transaction(act, ep, len, idx, val);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_address(logic [6:0] a);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= a;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    dev_addr = a;
  endtask

  task automatic fill_buffer();
    for (int i = 0; i < BufDepth; i++) begin
      send_transaction(ACT_LOAD, 4'h0, 7'd0, i[5:0], 8'($urandom));
    end
  endtask

  task automatic test_busy_at_zero_address();
    send_transaction(ACT_START, 4'hf, 7'd64, 6'd0, 8'h00);
    send_transaction(ACT_ACK, 4'h0, 7'd0, 6'd0, 8'h00);
    send_transaction(ACT_IGNORE, 4'hf, 7'h7f, 6'h3f, 8'hff);
  endtask

  task automatic test_directed_transfers();
    send_transaction(ACT_LOAD, 4'h0, 7'd0, 6'h3f, 8'hff);
    send_transaction(ACT_LOAD, 4'h0, 7'd0, 6'h00, 8'h00);
    send_transaction(ACT_START, 4'h0, 7'd0, 6'd0, 8'h00);
    send_transaction(ACT_START, 4'h3, 7'd5, 6'd0, 8'h00);
    send_transaction(ACT_ACK, 4'h0, 7'd0, 6'd0, 8'h00);
    send_transaction(ACT_START, 4'h5, 7'd0, 6'd0, 8'h00);
    send_transaction(ACT_OUT, 4'h5, 7'd0, 6'd0, 8'h00);
    send_transaction(ACT_DATA0, 4'h0, 7'd0, 6'd0, 8'h00);
    send_transaction(ACT_START, 4'hf, 7'd64, 6'd0, 8'h00);
    for (int i = 0; i < 8; i++) send_transaction(ACT_ACK, 4'h0, 7'd0, 6'd0, 8'h00);
    send_transaction(ACT_START, 4'h0, 7'd16, 6'd0, 8'h00);
    send_transaction(ACT_SETUP, 4'h0, 7'd0, 6'd0, 8'h00);
    send_transaction(ACT_DATA1, 4'h0, 7'd0, 6'd0, 8'h00);
    send_transaction(ACT_SETUP, 4'hf, 7'd0, 6'd0, 8'h00);
    send_transaction(ACT_ACK, 4'hf, 7'd0, 6'd0, 8'h00);
  endtask

  task automatic test_random_traffic(int unsigned count);
    int unsigned sel;
    logic [3:0] ep;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      ep = 4'($urandom);
      if (sel < 12) begin
        send_transaction(ACT_LOAD, ep, 7'($urandom), 6'($urandom), 8'($urandom));
      end else if (sel < 30) begin
        send_transaction(ACT_START, ep,
                         ($urandom_range(0, 7) == 0) ? 7'd64 : 7'($urandom_range(0, 24)),
                         6'($urandom), 8'($urandom));
      end else if (sel < 70) begin
        send_transaction(ACT_ACK, ep, 7'($urandom), 6'($urandom), 8'($urandom));
      end else if (sel < 77) begin
        send_transaction(ACT_SETUP, ep, 7'($urandom), 6'($urandom), 8'($urandom));
      end else if (sel < 85) begin
        send_transaction(ACT_OUT, ep, 7'($urandom), 6'($urandom), 8'($urandom));
      end else if (sel < 95) begin
        send_transaction($urandom_range(0, 1) ? ACT_DATA0 : ACT_DATA1, ep,
                         7'($urandom), 6'($urandom), 8'($urandom));
      end else begin
        send_transaction(ACT_IGNORE, ep, 7'($urandom_range(0, 127)), 6'($urandom),
                         8'($urandom));
      end
    end
  endtask

  task automatic test_pause_until_drained();
    send_transaction(ACT_START, 4'h0, 7'd8, 6'd0, 8'h00);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    send_transaction(ACT_ACK, 4'h0, 7'd0, 6'd0, 8'h00);
    send_transaction(ACT_ACK, 4'h0, 7'd0, 6'd0, 8'h00);
  endtask

  initial begin
    in_valid_i = 1'b0;
    action_i = ACT_IGNORE;
    endpoint_i = '0;
    transfer_length_i = '0;
    byte_index_i = '0;
    byte_value_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    mismatches = 0;
    toggles = '0;
    tok_ep = '0;
    xfer_ep = '0;
    tok_kind = TK_NONE;
    dev_addr = '0;
    clear_transmit();
    for (int i = 0; i < BufDepth; i++) buf_written[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_busy_at_zero_address();
    write_address(7'd127);
    fill_buffer();
    test_directed_transfers();
    test_pause_until_drained();
    write_address(7'd0);
    test_busy_at_zero_address();
    write_address(7'd1);
    test_random_traffic(115);
    write_address(7'($urandom_range(2, 126)));
    test_random_traffic(110);
    write_address(7'd127);
    test_random_traffic(110);

    wait_drained();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
